>>> hdl/shell_command_tokenizer_top_defines.svh
// ----------------------------------------------------------------------------
// Shell command tokenizer assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef SHELL_COMMAND_TOKENIZER_TOP_DEFINES_SVH
`define SHELL_COMMAND_TOKENIZER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define SCT_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sct: same-cycle property failed");

// Consequent must hold in the cycle after the antecedent
`define SCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sct: next-cycle property failed");

`endif

>>> hdl/sct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shell command tokenizer package
// Limits, character codes, result and lexer state types.
// ----------------------------------------------------------------------------
package sct_pkg;

  // Line and word limits
  localparam int MAX_TOKEN_COUNT = 64;
  localparam int MAX_WORD_BYTES  = 256;
  localparam int WORD_KEEP_LIMIT = ((MAX_WORD_BYTES - 1) > 255) ? 255 : (MAX_WORD_BYTES - 1);
  localparam int TCNT_W          = $clog2(MAX_TOKEN_COUNT + 1);

  // Result burst and queue sizing
  localparam int RES_MAX   = 4;
  localparam int RES_CNT_W = $clog2(RES_MAX + 1);
  localparam int RQ_DEPTH  = 8;
  localparam int RQ_PTR_W  = $clog2(RQ_DEPTH);

  // Character codes
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef enum logic [1:0] {
    KIND_CHAR     = 2'd0,
    KIND_WORD_END = 2'd1,
    KIND_OP       = 2'd2,
    KIND_LINE_END = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    OP_PIPE   = 4'd0,
    OP_OR     = 4'd1,
    OP_AND    = 4'd2,
    OP_BG     = 4'd3,
    OP_SEMI   = 4'd4,
    OP_IN     = 4'd5,
    OP_OUT    = 4'd6,
    OP_APPEND = 4'd7,
    OP_BOTH   = 4'd8
  } op_t;

  typedef enum logic [7:0] {
    MODE_NORMAL   = 8'b0000_0001,
    MODE_SQUOTE   = 8'b0000_0010,
    MODE_DQUOTE   = 8'b0000_0100,
    MODE_ESC      = 8'b0000_1000,
    MODE_DQ_ESC   = 8'b0001_0000,
    MODE_PEND_BAR = 8'b0010_0000,
    MODE_PEND_AMP = 8'b0100_0000,
    MODE_PEND_GT  = 8'b1000_0000
  } mode_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    op_t        op;
    logic [7:0] length;
    logic       last;
  } result_t;

  // Results raised by one character, in delivery order
  typedef struct packed {
    result_t [RES_MAX-1:0]  item;
    logic [RES_CNT_W-1:0]   count;
  } res_set_t;

  typedef struct packed {
    mode_t             mode;
    logic [7:0]        wlen;
    logic [TCNT_W-1:0] tcnt;
  } lex_state_t;

endpackage

>>> hdl/sct_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shell command tokenizer lexer step
// Combinational step: one character and the lexer state in, next state and
// up to four results out.
// ----------------------------------------------------------------------------
module sct_lexer (
  input  sct_pkg::lex_state_t st,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output sct_pkg::lex_state_t st_next,
  output sct_pkg::res_set_t   rs
);

  // Append one result to the burst
  function automatic void push(inout sct_pkg::res_set_t r, input sct_pkg::result_t x);
    if (r.count < sct_pkg::RES_CNT_W'(sct_pkg::RES_MAX)) begin
      r.item[r.count[$clog2(sct_pkg::RES_MAX)-1:0]] = x;
      r.count = r.count + sct_pkg::RES_CNT_W'(1);
    end
  endfunction

  function automatic logic room_for_token(input sct_pkg::lex_state_t s);
    return s.tcnt < sct_pkg::TCNT_W'(sct_pkg::MAX_TOKEN_COUNT);
  endfunction

  function automatic void end_word(inout sct_pkg::lex_state_t s, inout sct_pkg::res_set_t r);
    sct_pkg::result_t x;
    x = '0;
    x.kind = sct_pkg::KIND_WORD_END;
    x.length = s.wlen;
    if (s.wlen != 8'd0 && room_for_token(s)) begin
      push(r, x);
      s.tcnt = s.tcnt + sct_pkg::TCNT_W'(1);
    end
    s.wlen = 8'd0;
  endfunction

  function automatic void put_op(inout sct_pkg::lex_state_t s, inout sct_pkg::res_set_t r,
                                 input sct_pkg::op_t op);
    sct_pkg::result_t x;
    x = '0;
    x.kind = sct_pkg::KIND_OP;
    x.op = op;
    if (room_for_token(s)) begin
      push(r, x);
      s.tcnt = s.tcnt + sct_pkg::TCNT_W'(1);
    end
  endfunction

  // Keep a word character unless the word is full
  function automatic void keep_char(inout sct_pkg::lex_state_t s, inout sct_pkg::res_set_t r,
                                    input logic [7:0] c);
    sct_pkg::result_t x;
    x = '0;
    x.kind = sct_pkg::KIND_CHAR;
    x.data = c;
    if (s.wlen < 8'(sct_pkg::WORD_KEEP_LIMIT)) begin
      s.wlen = s.wlen + 8'd1;
      if (room_for_token(s)) push(r, x);
    end
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == sct_pkg::CH_SPACE) || (c >= sct_pkg::CH_TAB && c <= sct_pkg::CH_CR);
  endfunction

  // Character seen outside quotes and escapes
  function automatic void normal_byte(inout sct_pkg::lex_state_t s, inout sct_pkg::res_set_t r,
                                      input logic [7:0] c, input logic last);
    s.mode = sct_pkg::MODE_NORMAL;
    if (c == sct_pkg::CH_BSLASH && !last) begin
      s.mode = sct_pkg::MODE_ESC;
    end else if (c == sct_pkg::CH_SQUOTE) begin
      s.mode = sct_pkg::MODE_SQUOTE;
    end else if (c == sct_pkg::CH_DQUOTE) begin
      s.mode = sct_pkg::MODE_DQUOTE;
    end else if (is_blank(c)) begin
      end_word(s, r);
    end else begin
      case (c)
        sct_pkg::CH_BAR: begin
          end_word(s, r);
          if (last) put_op(s, r, sct_pkg::OP_PIPE);
          else s.mode = sct_pkg::MODE_PEND_BAR;
        end
        sct_pkg::CH_AMP: begin
          end_word(s, r);
          if (last) put_op(s, r, sct_pkg::OP_BG);
          else s.mode = sct_pkg::MODE_PEND_AMP;
        end
        sct_pkg::CH_GT: begin
          end_word(s, r);
          if (last) put_op(s, r, sct_pkg::OP_OUT);
          else s.mode = sct_pkg::MODE_PEND_GT;
        end
        sct_pkg::CH_SEMI: begin
          end_word(s, r);
          put_op(s, r, sct_pkg::OP_SEMI);
        end
        sct_pkg::CH_LT: begin
          end_word(s, r);
          put_op(s, r, sct_pkg::OP_IN);
        end
        default: keep_char(s, r, c);
      endcase
    end
  endfunction

  // Walk one character through the lexer modes
  always_comb begin
    sct_pkg::lex_state_t s;
    sct_pkg::res_set_t   r;
    sct_pkg::result_t    x;
    s = st;
    r = '0;
    x = '0;
    unique case (st.mode)
      sct_pkg::MODE_SQUOTE: begin
        if (in_byte == sct_pkg::CH_SQUOTE) s.mode = sct_pkg::MODE_NORMAL;
        else keep_char(s, r, in_byte);
      end
      sct_pkg::MODE_DQUOTE: begin
        if (in_byte == sct_pkg::CH_DQUOTE) s.mode = sct_pkg::MODE_NORMAL;
        else if (in_byte == sct_pkg::CH_BSLASH && !in_last) s.mode = sct_pkg::MODE_DQ_ESC;
        else keep_char(s, r, in_byte);
      end
      sct_pkg::MODE_ESC: begin
        keep_char(s, r, in_byte);
        s.mode = sct_pkg::MODE_NORMAL;
      end
      sct_pkg::MODE_DQ_ESC: begin
        keep_char(s, r, in_byte);
        s.mode = sct_pkg::MODE_DQUOTE;
      end
      sct_pkg::MODE_PEND_BAR: begin
        s.mode = sct_pkg::MODE_NORMAL;
        if (in_byte == sct_pkg::CH_BAR) begin
          put_op(s, r, sct_pkg::OP_OR);
        end else begin
          put_op(s, r, sct_pkg::OP_PIPE);
          normal_byte(s, r, in_byte, in_last);
        end
      end
      sct_pkg::MODE_PEND_AMP: begin
        s.mode = sct_pkg::MODE_NORMAL;
        if (in_byte == sct_pkg::CH_AMP) begin
          put_op(s, r, sct_pkg::OP_AND);
        end else if (in_byte == sct_pkg::CH_GT) begin
          put_op(s, r, sct_pkg::OP_BOTH);
        end else begin
          put_op(s, r, sct_pkg::OP_BG);
          normal_byte(s, r, in_byte, in_last);
        end
      end
      sct_pkg::MODE_PEND_GT: begin
        s.mode = sct_pkg::MODE_NORMAL;
        if (in_byte == sct_pkg::CH_GT) begin
          put_op(s, r, sct_pkg::OP_APPEND);
        end else begin
          put_op(s, r, sct_pkg::OP_OUT);
          normal_byte(s, r, in_byte, in_last);
        end
      end
      default: normal_byte(s, r, in_byte, in_last);
    endcase

    // Close the line and return to the reset state
    if (in_last) begin
      end_word(s, r);
      x.kind = sct_pkg::KIND_LINE_END;
      push(r, x);
      s.mode = sct_pkg::MODE_NORMAL;
      s.wlen = 8'd0;
      s.tcnt = '0;
    end

    // Flag the final result of the burst
    if (r.count != '0) begin
      r.item[r.count[$clog2(sct_pkg::RES_MAX)-1:0] - 1'b1].last = 1'b1;
    end

    st_next = s;
    rs = r;
  end

endmodule

>>> hdl/sct_result_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shell command tokenizer result queue
// Takes a burst of up to four results in one cycle; one leaves a cycle on pop.
// ----------------------------------------------------------------------------
module sct_result_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sct_pkg::res_set_t   push_set,
  input  logic                pop,
  output logic                room,
  output logic                head_valid,
  output sct_pkg::result_t    head
);

  sct_pkg::result_t                slots [sct_pkg::RQ_DEPTH];
  logic [sct_pkg::RQ_PTR_W-1:0]    rd_ptr;
  logic [sct_pkg::RQ_PTR_W-1:0]    wr_ptr;
  logic [sct_pkg::RQ_PTR_W:0]      count;
  logic [sct_pkg::RES_CNT_W-1:0]   push_n;
  logic                            pop_en;

  assign push_n     = push ? push_set.count : '0;
  assign head_valid = (count != '0);
  assign pop_en     = pop && head_valid;
  assign head       = slots[rd_ptr];

  // Room flags a new burst only while a whole one fits; push is not gated on it
  assign room = (count <= (sct_pkg::RQ_PTR_W+1)'(sct_pkg::RQ_DEPTH - sct_pkg::RES_MAX));

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + sct_pkg::RQ_PTR_W'(push_n);
      if (pop_en) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (sct_pkg::RQ_PTR_W+1)'(push_n) - (sct_pkg::RQ_PTR_W+1)'(pop_en);
    end
  end

  // Write the burst into consecutive slots
  always_ff @(posedge clk) begin
    for (int i = 0; i < sct_pkg::RES_MAX; i++) begin
      if (sct_pkg::RES_CNT_W'(i) < push_n) begin
        slots[wr_ptr + sct_pkg::RQ_PTR_W'(i)] <= push_set.item[i];
      end
    end
  end

endmodule

>>> hdl/shell_command_tokenizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shell command tokenizer
// Splits a command line, one character per request, into word characters,
// word ends, operator codes and a line end.
// ----------------------------------------------------------------------------
// The block takes one character per cycle, while in_stall is low, into an
// input register; once the queue has room, it runs the character through the
// lexer and drops its zero to four results into an eight-entry result queue;
// a result passes the input register and the queue before it can leave. A new
// character is accepted in every cycle while the queue holds four results or
// fewer, and results leave at one per cycle while out_stall is low, so the
// sustained rate is one character per cycle for as long as characters average
// at most one result each; longer bursts are absorbed by the queue and then
// paced by the output port.
module shell_command_tokenizer_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic [3:0] out_op,
  output logic [7:0] out_length,
  output logic       out_last
);

  logic                stage_valid;
  logic [7:0]          stage_byte;
  logic                stage_last;
  logic                accept;
  logic                advance;
  logic                room;
  sct_pkg::lex_state_t lex_state;
  sct_pkg::lex_state_t lex_state_next;
  sct_pkg::res_set_t   burst;
  sct_pkg::result_t    head;

  assign advance  = stage_valid && room;
  assign in_stall = stage_valid && !advance;
  assign accept   = in_valid && !in_stall;

  // Hold the request in the input register until the queue has room
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_byte <= in_byte;
      stage_last <= in_last;
    end
  end

  // Lexer state advances once per character
  always_ff @(posedge clk) begin
    if (rst) begin
      lex_state.mode <= sct_pkg::MODE_NORMAL;
      lex_state.wlen <= 8'd0;
      lex_state.tcnt <= '0;
    end else if (advance) begin
      lex_state <= lex_state_next;
    end
  end

  sct_lexer u_lexer (
    .st      (lex_state),
    .in_byte (stage_byte),
    .in_last (stage_last),
    .st_next (lex_state_next),
    .rs      (burst)
  );

  sct_result_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (advance),
    .push_set   (burst),
    .pop        (!out_stall),
    .room       (room),
    .head_valid (out_valid),
    .head       (head)
  );

  // Drive result fields from the queue head
  assign out_kind   = head.kind;
  assign out_byte   = head.data;
  assign out_op     = head.op;
  assign out_length = head.length;
  assign out_last   = head.last;

endmodule

>>> hdl/sct_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shell command tokenizer port checker
// Watches the result port of the top level over time.
// ----------------------------------------------------------------------------
`include "shell_command_tokenizer_top_defines.svh"

module sct_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_kind,
  input logic [7:0] out_byte,
  input logic [3:0] out_op,
  input logic [7:0] out_length,
  input logic       out_last
);

  // Stalled result holds
  `SCT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_kind) && $stable(out_byte) && $stable(out_op) && $stable(out_length) && $stable(out_last))

  // A line end always closes the burst of its character
  `SCT_ASSERT_SAME(a_line_end_last, clk, rst, out_valid && out_kind == sct_pkg::KIND_LINE_END, out_last)

  // Empty words never report an end
  `SCT_ASSERT_SAME(a_word_len, clk, rst, out_valid && out_kind == sct_pkg::KIND_WORD_END, out_length != 8'd0)

  // Operator codes stay within the defined set
  `SCT_ASSERT_SAME(a_op_code, clk, rst, out_valid && out_kind == sct_pkg::KIND_OP, out_op <= sct_pkg::OP_BOTH)

endmodule

bind shell_command_tokenizer_top sct_checker u_checker (.*);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shell command tokenizer testbench
// Streams command lines through the tokenizer with random bursts, gaps and
// output stalls. A scoreboard runs a lexer of its own over every accepted
// character and compares each result that leaves the block, field by field,
// against the oldest expected one. It covers directed lines (operators,
// quotes, escapes, a trailing backslash), shell-like random lines, noise
// lines, a word past the length limit and a line past the token limit.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TARGET_CHARS = 350;
  localparam int HOLD_CYCLES = 400;

  // Shapes of generated lines
  localparam int SHAPE_SHELL = 0;
  localparam int SHAPE_NOISE = 1;
  localparam int SHAPE_LONG_WORD = 2;
  localparam int SHAPE_FLOOD = 3;

  // Scoreboard: tracks the lexer state and holds the expected results
  class token_scoreboard;
    sct_pkg::result_t expected_q[$];
    sct_pkg::result_t step_q[$];
    sct_pkg::mode_t mode;
    logic [7:0] wlen;
    int unsigned tcount;
    bit dropped;
    int unsigned accepted;
    int unsigned errors;

    function new();
      clear_line();
      accepted = 0;
      errors = 0;
    endfunction

    function void clear_line();
      mode = sct_pkg::MODE_NORMAL;
      wlen = 8'd0;
      tcount = 0;
      dropped = 0;
    endfunction

    // Queue one result of the current request, at most four per request
    function void add_result(sct_pkg::kind_t k, logic [7:0] d, sct_pkg::op_t o,
                             logic [7:0] l);
      sct_pkg::result_t r;
      if (step_q.size() < sct_pkg::RES_MAX) begin
        r.kind = k;
        r.data = d;
        r.op = o;
        r.length = l;
        r.last = 1'b0;
        step_q.push_back(r);
      end
    endfunction

    // Close the current word; an empty word gives nothing. Op field is zero
    // (the pipe code) on every result that is not an operator.
    function void close_word();
      if (wlen > 0 && tcount < sct_pkg::MAX_TOKEN_COUNT) begin
        add_result(sct_pkg::KIND_WORD_END, 8'd0, sct_pkg::OP_PIPE, wlen);
        tcount++;
      end
      wlen = 8'd0;
      dropped = 0;
    endfunction

    function void put_op(sct_pkg::op_t o);
      if (tcount < sct_pkg::MAX_TOKEN_COUNT) begin
        add_result(sct_pkg::KIND_OP, 8'd0, o, 8'd0);
        tcount++;
      end
    endfunction

    // Keep a word character unless the word is full
    function void keep_char(logic [7:0] c);
      if (wlen < sct_pkg::WORD_KEEP_LIMIT) begin
        wlen++;
        if (tcount < sct_pkg::MAX_TOKEN_COUNT) begin
          add_result(sct_pkg::KIND_CHAR, c, sct_pkg::OP_PIPE, 8'd0);
        end
      end else begin
        dropped = 1;
      end
    endfunction

    // Character seen outside quotes with no operator pending
    function void plain_char(logic [7:0] c, logic fin);
      mode = sct_pkg::MODE_NORMAL;
      if (c == sct_pkg::CH_BSLASH && !fin) begin
        mode = sct_pkg::MODE_ESC;
      end else if (c == sct_pkg::CH_SQUOTE) begin
        mode = sct_pkg::MODE_SQUOTE;
      end else if (c == sct_pkg::CH_DQUOTE) begin
        mode = sct_pkg::MODE_DQUOTE;
      end else if (c == sct_pkg::CH_SPACE || (c >= sct_pkg::CH_TAB && c <= sct_pkg::CH_CR)) begin
        close_word();
      end else if (c == sct_pkg::CH_BAR) begin
        close_word();
        if (fin) put_op(sct_pkg::OP_PIPE);
        else mode = sct_pkg::MODE_PEND_BAR;
      end else if (c == sct_pkg::CH_AMP) begin
        close_word();
        if (fin) put_op(sct_pkg::OP_BG);
        else mode = sct_pkg::MODE_PEND_AMP;
      end else if (c == sct_pkg::CH_GT) begin
        close_word();
        if (fin) put_op(sct_pkg::OP_OUT);
        else mode = sct_pkg::MODE_PEND_GT;
      end else if (c == sct_pkg::CH_SEMI) begin
        close_word();
        put_op(sct_pkg::OP_SEMI);
      end else if (c == sct_pkg::CH_LT) begin
        close_word();
        put_op(sct_pkg::OP_IN);
      end else begin
        keep_char(c);
      end
    endfunction

    // Note an accepted request and queue the results it causes
    function void note_char(logic [7:0] c, logic fin);
      step_q.delete();
      accepted++;
      case (mode)
        sct_pkg::MODE_SQUOTE: begin
          if (c == sct_pkg::CH_SQUOTE) mode = sct_pkg::MODE_NORMAL;
          else keep_char(c);
        end
        sct_pkg::MODE_DQUOTE: begin
          if (c == sct_pkg::CH_DQUOTE) mode = sct_pkg::MODE_NORMAL;
          else if (c == sct_pkg::CH_BSLASH && !fin) mode = sct_pkg::MODE_DQ_ESC;
          else keep_char(c);
        end
        sct_pkg::MODE_ESC: begin
          keep_char(c);
          mode = sct_pkg::MODE_NORMAL;
        end
        sct_pkg::MODE_DQ_ESC: begin
          keep_char(c);
          mode = sct_pkg::MODE_DQUOTE;
        end
        sct_pkg::MODE_PEND_BAR: begin
          mode = sct_pkg::MODE_NORMAL;
          if (c == sct_pkg::CH_BAR) begin
            put_op(sct_pkg::OP_OR);
          end else begin
            put_op(sct_pkg::OP_PIPE);
            plain_char(c, fin);
          end
        end
        sct_pkg::MODE_PEND_AMP: begin
          mode = sct_pkg::MODE_NORMAL;
          if (c == sct_pkg::CH_AMP) begin
            put_op(sct_pkg::OP_AND);
          end else if (c == sct_pkg::CH_GT) begin
            put_op(sct_pkg::OP_BOTH);
          end else begin
            put_op(sct_pkg::OP_BG);
            plain_char(c, fin);
          end
        end
        sct_pkg::MODE_PEND_GT: begin
          mode = sct_pkg::MODE_NORMAL;
          if (c == sct_pkg::CH_GT) begin
            put_op(sct_pkg::OP_APPEND);
          end else begin
            put_op(sct_pkg::OP_OUT);
            plain_char(c, fin);
          end
        end
        default: plain_char(c, fin);
      endcase
      // Finish the line and start afresh
      if (fin) begin
        close_word();
        add_result(sct_pkg::KIND_LINE_END, 8'd0, sct_pkg::OP_PIPE, 8'd0);
        clear_line();
      end
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
      foreach (step_q[i]) expected_q.push_back(step_q[i]);
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    // Compare an accepted result with the oldest expected one
    function void check_result(sct_pkg::result_t got);
      sct_pkg::result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result: kind=%0d byte=%02h op=%0d len=%0d last=%0b",
                         got.kind, got.data, got.op, got.length, got.last));
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind || got.data !== want.data || got.op !== want.op ||
          got.length !== want.length || got.last !== want.last) begin
        report($sformatf({"result mismatch: expected kind=%0d byte=%02h op=%0d len=%0d",
                          " last=%0b, got kind=%0d byte=%02h op=%0d len=%0d last=%0b"},
                         want.kind, want.data, want.op, want.length, want.last,
                         got.kind, got.data, got.op, got.length, got.last));
      end
    endfunction
  endclass

  typedef struct {
    logic [7:0] ch;
    logic       fin;
  } line_char_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic [3:0] out_op;
  logic [7:0] out_length;
  logic       out_last;

  token_scoreboard sb = new();
  line_char_t stim_q[$];
  int unsigned cycle_count = 0;

  string op_text[9] = '{"|", "||", "&", "&&", "&>", ";", ">", ">>", "<"};
  logic [7:0] blank_chars[6] = '{sct_pkg::CH_SPACE, sct_pkg::CH_TAB, 8'h0A, 8'h0B, 8'h0C,
                                 sct_pkg::CH_CR};

  shell_command_tokenizer_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .out_op    (out_op),
    .out_length(out_length),
    .out_last  (out_last)
  );

  always #5 clk = ~clk;

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Sample both handshakes at the clock edge
  always @(posedge clk) begin : port_monitor
    sct_pkg::result_t seen;
    if (!rst && in_valid && !in_stall) sb.note_char(in_byte, in_last);
    if (!rst && out_valid && !out_stall) begin
      seen.kind = sct_pkg::kind_t'(out_kind);
      seen.data = out_byte;
      seen.op = sct_pkg::op_t'(out_op);
      seen.length = out_length;
      seen.last = out_last;
      sb.check_result(seen);
    end
  end

  function automatic void add_byte(logic [7:0] b);
    line_char_t e;
    e.ch = b;
    e.fin = 1'b0;
    stim_q.push_back(e);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  // Mark the final character of a line begun at start
  function automatic void close_line(int start);
    if (stim_q.size() == start) add_byte("x");
    stim_q[stim_q.size() - 1].fin = 1'b1;
  endfunction

  // Any character that neither quotes, escapes nor forms an operator
  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do begin
      c = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(128, 255))
                                      : 8'($urandom_range(33, 126));
    end while (c inside {sct_pkg::CH_BAR, sct_pkg::CH_AMP, sct_pkg::CH_SEMI,
                         sct_pkg::CH_GT, sct_pkg::CH_LT, sct_pkg::CH_DQUOTE,
                         sct_pkg::CH_SQUOTE, sct_pkg::CH_BSLASH});
    return c;
  endfunction

  // Append one generated line of the given shape
  function automatic void add_line(int shape);
    int start;
    start = stim_q.size();
    case (shape)
      SHAPE_NOISE: begin
        repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
      end
      SHAPE_LONG_WORD: begin
        repeat ($urandom_range(256, 262)) add_byte(word_char());
        add_byte(sct_pkg::CH_SPACE);
        add_text("tail");
      end
      SHAPE_FLOOD: begin
        // well past the token limit: a word and an operator on every step
        repeat (36) begin
          add_byte(word_char());
          add_text(op_text[$urandom_range(0, 8)]);
        end
      end
      default: begin
        repeat ($urandom_range(1, 7)) begin
          case ($urandom_range(0, 7))
            0, 1, 2: repeat ($urandom_range(1, 5)) add_byte(word_char());
            3: begin
              add_byte(sct_pkg::CH_SQUOTE);
              repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)));
              add_byte(sct_pkg::CH_SQUOTE);
            end
            4: begin
              add_byte(sct_pkg::CH_DQUOTE);
              repeat ($urandom_range(0, 3)) begin
                if ($urandom_range(0, 2) == 0) begin
                  add_byte(sct_pkg::CH_BSLASH);
                  add_byte(8'($urandom_range(0, 255)));
                end else begin
                  add_byte(word_char());
                end
              end
              add_byte(sct_pkg::CH_DQUOTE);
            end
            5: begin
              add_byte(sct_pkg::CH_BSLASH);
              add_byte(8'($urandom_range(0, 255)));
            end
            6: add_text(op_text[$urandom_range(0, 8)]);
            default: add_byte(blank_chars[$urandom_range(0, 5)]);
          endcase
        end
        // Sometimes end on a backslash or inside an open quote
        case ($urandom_range(0, 9))
          0: add_byte(sct_pkg::CH_BSLASH);
          1: begin
            add_byte(sct_pkg::CH_DQUOTE);
            add_byte(word_char());
          end
          2: begin
            add_byte(sct_pkg::CH_SQUOTE);
            add_byte(word_char());
          end
          default: ;
        endcase
      end
    endcase
    close_line(start);
  endfunction

  // Offer every character, in bursts with random gaps
  task automatic drive_chars();
    int idx;
    int burst;
    int gap;
    idx = 0;
    while (idx < stim_q.size()) begin
      burst = $urandom_range(1, 32);
      while (burst > 0 && idx < stim_q.size()) begin
        in_valid <= 1'b1;
        in_byte <= stim_q[idx].ch;
        in_last <= stim_q[idx].fin;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        idx++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  // Output stalls: random stretches, plus one long hold-off to fill the block
  initial begin : receive_side
    int span;
    int pct;
    bit held;
    held = 0;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && sb.accepted >= 150) begin
        held = 1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        span = $urandom_range(4, 40);
        case ($urandom_range(0, 3))
          0: pct = 0;
          1: pct = 30;
          2: pct = 70;
          default: pct = 50;
        endcase
        repeat (span) begin
          out_stall <= ($urandom_range(0, 99) < pct);
          @(posedge clk);
        end
      end
    end
  end

  initial begin : main_seq
    int start;
    bit long_done;
    bit flood_done;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_byte <= 8'd0;
    in_last <= 1'b0;

    // Escaped pipe, or, and an output redirect ending on a literal backslash
    start = stim_q.size();
    add_text("\\|x||a>\\");
    close_line(start);
    // Every operator but the or, pending ones resolved by the next character
    start = stim_q.size();
    add_text("|&&&>&;<>>>");
    close_line(start);
    // Empty quotes, escaped quote, zero and top bytes, open quote at line end
    start = stim_q.size();
    add_text("'' \"\\\"");
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(sct_pkg::CH_BSLASH);
    close_line(start);

    // Random lines; one long word and one token flood on the way
    long_done = 0;
    flood_done = 0;
    while (stim_q.size() < TARGET_CHARS || !long_done || !flood_done) begin
      add_line(($urandom_range(0, 4) == 0) ? SHAPE_NOISE : SHAPE_SHELL);
      if (!long_done && stim_q.size() > 45) begin
        add_line(SHAPE_LONG_WORD);
        long_done = 1;
      end else if (long_done && !flood_done) begin
        add_line(SHAPE_FLOOD);
        flood_done = 1;
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    drive_chars();

    // Drain, then allow for stray late results
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/sct_pkg.sv
hdl/sct_lexer.sv
hdl/sct_result_fifo.sv
hdl/shell_command_tokenizer_top.sv
hdl/sct_checker.sv
tb/tb_top.sv
